### hw/rtl/dtd_pkg.sv
// Shared constants, types and helpers for the detector trigger decision core.
package dtd_pkg;

	localparam int unsigned TIME_W = 32;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam int unsigned FRAME_TICKS_DEF = 1024;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 18;

	localparam int unsigned ENABLE_W = 18;
	localparam int unsigned FRAMES_W = 8;
	localparam int unsigned WIDTH_W  = 16;
	localparam int unsigned COND_W   = 3;
	localparam int unsigned NUM_BEAMS = 2;

	localparam logic [ENABLE_W-1:0] ENABLE_RST = '0;
	localparam logic [FRAMES_W-1:0] FRAMES_RST = 8'd4;
	localparam logic [WIDTH_W-1:0]  GATE_WIDTH_RST = 16'd102;
	localparam logic [WIDTH_W-1:0]  ALLOW_RST = '0;

	localparam int unsigned BEAM_A = 0;
	localparam int unsigned BEAM_B = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE      = 3'd0,
		CFG_DEADTIME    = 3'd1,
		CFG_GATE_A      = 3'd2,
		CFG_GATE_B      = 3'd3,
		CFG_ALLOW_A_MIN = 3'd4,
		CFG_ALLOW_A_MAX = 3'd5,
		CFG_ALLOW_B_MIN = 3'd6,
		CFG_ALLOW_B_MAX = 3'd7
	} cfg_idx_t;

	// t + d, held at the top of the time range
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
		input logic [TIME_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {1'b0, d};
		sat_add = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic in_window(input logic v, input logic [TIME_W-1:0] s,
		input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] t);
		in_window = v && (t >= s) && (t <= e);
	endfunction

endpackage

### hw/rtl/detector_trigger_decision_core.sv
// Detector trigger decision core: deadtime, beam gates, allow windows, trigger numbering.
//
// Candidates enter on the in channel (in_valid/in_ready) in rising time order and
// each gives exactly one word on the out channel (out_valid/out_ready): fired,
// in_deadtime, conditions and trigger_number (zero when not fired).
// A candidate is registered at acceptance, decided against the deadtime, gate and
// allow-window state once the result register can take a word, and its word is registered.
// State updates in the same edge as the word is registered, so the next candidate sees
// it at once: one candidate per cycle sustained while the receiver takes every word.
// The rate is set by the single decision stage between the input register and
// the result register; the state loop closes inside that stage.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more candidate; in_ready drops once both are full.
// Reset clears deadtime, gates, windows and the trigger count and loads the default
// register values (deadtime 4 frames, gate widths 102 ticks). The deadtime span is
// precomputed when its register is written. Registers are written by the user through
// cfg_we/cfg_index/cfg_data while no candidate is in flight, not enforced by the core.
module detector_trigger_decision_core
	import dtd_pkg::*;
#(
	parameter int unsigned FRAME_TICKS = FRAME_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TIME_W-1:0]     cand_time,
	input  logic                  pmt_cosmic,
	input  logic                  pmt_beam,
	input  logic                  beam_a,
	input  logic                  beam_b,
	input  logic                  calib,
	input  logic                  external,
	input  logic                  computer,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  fired,
	output logic                  in_deadtime,
	output logic [COND_W-1:0]     conditions,
	output logic [TIME_W-1:0]     trigger_number
);

	// deadtime span minus one fits below 255 * FRAME_TICKS
	localparam int unsigned SPAN_W = $clog2(255 * FRAME_TICKS + 1);
	localparam logic [SPAN_W-1:0] SPAN_RST =
		SPAN_W'(int'(FRAMES_RST) * FRAME_TICKS - 1);

	// configuration
	logic [ENABLE_W-1:0] enable_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [SPAN_W-1:0]   span_q;
	logic [WIDTH_W-1:0]  gate_width_q [NUM_BEAMS];
	logic [WIDTH_W-1:0]  allow_min_q  [NUM_BEAMS];
	logic [WIDTH_W-1:0]  allow_max_q  [NUM_BEAMS];

	// decision state
	logic [TIME_W-1:0] dead_end_q;
	logic              dead_valid_q;
	logic [TIME_W-1:0] gate_start_q  [NUM_BEAMS];
	logic [TIME_W-1:0] gate_end_q    [NUM_BEAMS];
	logic              gate_valid_q  [NUM_BEAMS];
	logic [TIME_W-1:0] allow_start_q [NUM_BEAMS];
	logic [TIME_W-1:0] allow_end_q   [NUM_BEAMS];
	logic              allow_valid_q [NUM_BEAMS];
	logic [TIME_W-1:0] count_q;

	// input stage
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              pmt_cosmic_s1;
	logic              pmt_beam_s1;
	logic              beam_s1 [NUM_BEAMS];
	logic              calib_s1;
	logic              external_s1;
	logic              computer_s1;

	// result stage
	logic              valid_s2;
	logic              fired_s2;
	logic              in_deadtime_s2;
	logic [COND_W-1:0] conditions_s2;
	logic [TIME_W-1:0] trigger_number_s2;

	logic              advance;
	logic              dead_hit;
	logic              act;
	logic              ga;
	logic              gb;
	logic [3:0]        m0;
	logic [3:0]        m1;
	logic [6:0]        m8;
	logic              s0;
	logic              s1;
	logic              s8;
	logic              p0;
	logic              p1;
	logic              p8;
	logic [COND_W-1:0] cond;
	logic              trig;
	logic [TIME_W-1:0] dead_end_nxt;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		m0 = enable_q[3:0];
		m1 = enable_q[7:4];
		m8 = enable_q[14:8];
		s0 = enable_q[15];
		s1 = enable_q[16];
		s8 = enable_q[17];

		dead_hit = dead_valid_q && (time_s1 <= dead_end_q);
		act = in_window(allow_valid_q[BEAM_A], allow_start_q[BEAM_A],
				allow_end_q[BEAM_A], time_s1) ||
			in_window(allow_valid_q[BEAM_B], allow_start_q[BEAM_B],
				allow_end_q[BEAM_B], time_s1);
		// a gate opened by this candidate always holds its own time
		ga = beam_s1[BEAM_A] || in_window(gate_valid_q[BEAM_A], gate_start_q[BEAM_A],
			gate_end_q[BEAM_A], time_s1);
		gb = beam_s1[BEAM_B] || in_window(gate_valid_q[BEAM_B], gate_start_q[BEAM_B],
			gate_end_q[BEAM_B], time_s1);

		p0 = pmt_cosmic_s1 && ((beam_s1[BEAM_B] && m0[0]) || (beam_s1[BEAM_A] && m0[1]) ||
			(act && m0[2] && !s0) || (m0[3] && !s0));
		p1 = pmt_beam_s1 && ((beam_s1[BEAM_B] && m1[0]) || (beam_s1[BEAM_A] && m1[1]) ||
			(act && m1[2] && !s1) || (m1[3] && !s1));
		p8 = (act && external_s1 && m8[0] && !s8) ||
			(external_s1 && m8[1] && !s8) ||
			(act && computer_s1 && m8[2]) ||
			(computer_s1 && m8[3]) ||
			(ga && m8[4]) ||
			(gb && m8[5]) ||
			(calib_s1 && m8[6]);

		cond = dead_hit ? '0 : {p8, p1, p0};
		trig = |cond;
		dead_end_nxt = sat_add(time_s1, TIME_W'(span_q));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			frames_q <= FRAMES_RST;
			span_q   <= SPAN_RST;
			for (int i = 0; i < NUM_BEAMS; i++) begin
				gate_width_q[i] <= GATE_WIDTH_RST;
				allow_min_q[i]  <= ALLOW_RST;
				allow_max_q[i]  <= ALLOW_RST;
			end
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE: begin
					enable_q <= cfg_data[ENABLE_W-1:0];
				end
				CFG_DEADTIME: begin
					frames_q <= cfg_data[FRAMES_W-1:0];
					// zero frames wraps here, but the deadtime is then left invalid, so the span has no effect
					span_q <= SPAN_W'(int'(cfg_data[FRAMES_W-1:0]) * FRAME_TICKS - 1);
				end
				CFG_GATE_A:      gate_width_q[BEAM_A] <= cfg_data[WIDTH_W-1:0];
				CFG_GATE_B:      gate_width_q[BEAM_B] <= cfg_data[WIDTH_W-1:0];
				CFG_ALLOW_A_MIN: allow_min_q[BEAM_A]  <= cfg_data[WIDTH_W-1:0];
				CFG_ALLOW_A_MAX: allow_max_q[BEAM_A]  <= cfg_data[WIDTH_W-1:0];
				CFG_ALLOW_B_MIN: allow_min_q[BEAM_B]  <= cfg_data[WIDTH_W-1:0];
				CFG_ALLOW_B_MAX: allow_max_q[BEAM_B]  <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1         <= cand_time;
			pmt_cosmic_s1   <= pmt_cosmic;
			pmt_beam_s1     <= pmt_beam;
			beam_s1[BEAM_A] <= beam_a;
			beam_s1[BEAM_B] <= beam_b;
			calib_s1        <= calib;
			external_s1     <= external;
			computer_s1     <= computer;
		end
	end

	// decision state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_end_q   <= '0;
			dead_valid_q <= 1'b0;
			count_q      <= '0;
			for (int i = 0; i < NUM_BEAMS; i++) begin
				gate_start_q[i]  <= '0;
				gate_end_q[i]    <= '0;
				gate_valid_q[i]  <= 1'b0;
				allow_start_q[i] <= '0;
				allow_end_q[i]   <= '0;
				allow_valid_q[i] <= 1'b0;
			end
		end else if (advance && !dead_hit) begin
			for (int i = 0; i < NUM_BEAMS; i++) begin
				if (beam_s1[i]) begin
					gate_start_q[i] <= time_s1;
					gate_end_q[i]   <= sat_add(time_s1, TIME_W'(gate_width_q[i]));
					gate_valid_q[i] <= 1'b1;
				end
			end
			if (trig) begin
				dead_valid_q <= (frames_q != '0);
				dead_end_q   <= dead_end_nxt;
				count_q      <= count_q + TIME_W'(1);
				for (int i = 0; i < NUM_BEAMS; i++) begin
					if (beam_s1[i]) begin
						allow_start_q[i] <= sat_add(time_s1, TIME_W'(allow_min_q[i]));
						allow_end_q[i]   <= sat_add(time_s1, TIME_W'(allow_max_q[i]));
						allow_valid_q[i] <= (allow_min_q[i] <= allow_max_q[i]);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_s2          <= trig;
			in_deadtime_s2    <= dead_hit;
			conditions_s2     <= cond;
			trigger_number_s2 <= trig ? count_q : '0;
		end
	end

	assign out_valid      = valid_s2;
	assign fired          = fired_s2;
	assign in_deadtime    = in_deadtime_s2;
	assign conditions     = conditions_s2;
	assign trigger_number = trigger_number_s2;

endmodule
